// ----- rtl/core/mhpq_pkg.sv -----
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CNT_W   = 7;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e                       operation;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] popped_value;
    logic signed [VALUE_W-1:0] minimum;
    logic [CNT_W-1:0]          entry_count;
    logic                      is_empty;
  } out_item_t;

  typedef struct packed {
    logic                      push;
    logic                      pop;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- rtl/core/mhpq_cell.sv -----
`timescale 1ns / 1ps

module mhpq_cell (
  input  logic                               clk_i,
  input  mhpq_pkg::cell_cmd_t                cmd_i,
  input  logic                               valid_i,
  input  logic signed [mhpq_pkg::VALUE_W-1:0] left_val_i,
  input  logic                               left_gt_i,
  input  logic signed [mhpq_pkg::VALUE_W-1:0] right_val_i,
  output logic signed [mhpq_pkg::VALUE_W-1:0] val_o,
  output logic                               gt_o
);
  import mhpq_pkg::*;

  logic signed [VALUE_W-1:0] val_q;
  logic signed [VALUE_W-1:0] val_d;

  assign gt_o  = !valid_i || (val_q > cmd_i.value);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (cmd_i.push && gt_o) begin
      val_d = left_gt_i ? left_val_i : cmd_i.value;
    end else if (cmd_i.pop) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ----- rtl/core/min_heap_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// Priority queue of signed 32-bit values, smallest out first.
// Input channel (in_valid_i / in_ready_o / in_i): each transaction is a push
// of in_i.value or a pop of the minimum. Output channel (out_valid_o /
// out_ready_i / out_o): exactly one result transaction per input transaction,
// carrying the status, the popped value, the new minimum, the entry count
// and an empty flag.
// Storage is a sorted row of DEPTH cells; every cell compares its entry with
// the incoming value and shifts toward or away from its neighbor in the
// same cycle. The result is registered into out_o in the cycle after the
// input transaction. Throughput: one transaction per cycle while the
// receiver takes each result. When the receiver stalls, the result register
// holds and in_ready_o drops until the result is taken. Capacity is written
// via cfg_we_i / cfg_wdata_i; the user must write it only while idle, the
// block does not enforce this. Values above DEPTH saturate. Reset empties
// the queue, sets capacity to 64 and clears the output valid; cell contents
// are not cleared.
module min_heap_priority_queue_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mhpq_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mhpq_pkg::out_item_t out_o,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i
);
  import mhpq_pkg::*;

  localparam int unsigned CapMax = (DEPTH < 127) ? DEPTH : 127;

  logic [CNT_W-1:0] capacity_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] limit;
  logic             out_valid_q;
  out_item_t        out_q, out_d;
  logic             accept;
  cell_cmd_t        cmd;

  logic signed [VALUE_W-1:0] cell_val [DEPTH];
  logic                      cell_gt  [DEPTH];

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign limit = (capacity_q > CNT_W'(CapMax)) ? CNT_W'(CapMax) : capacity_q;

  always_comb begin
    cmd       = '0;
    cmd.value = in_i.value;
    cmd.push  = accept && (in_i.operation == OP_PUSH) && (count_q < limit);
    cmd.pop   = accept && (in_i.operation == OP_POP) && (count_q != '0);
  end

  always_comb begin
    count_d = count_q;
    out_d   = '0;
    unique case (in_i.operation)
      OP_PUSH: begin
        if (count_q >= limit) begin
          out_d.status  = ST_FULL;
          out_d.minimum = (count_q != '0) ? cell_val[0] : '0;
        end else begin
          count_d       = count_q + CNT_W'(1);
          out_d.status  = ST_DONE;
          out_d.minimum = cell_gt[0] ? in_i.value : cell_val[0];
        end
      end
      OP_POP: begin
        if (count_q == '0) begin
          out_d.status = ST_EMPTY;
        end else begin
          count_d            = count_q - CNT_W'(1);
          out_d.status       = ST_DONE;
          out_d.popped_value = cell_val[0];
          out_d.minimum      = (count_q > CNT_W'(1)) ? cell_val[1] : '0;
        end
      end
      default: begin
        out_d.status = ST_DONE;
      end
    endcase
    out_d.entry_count = count_d;
    out_d.is_empty    = (count_d == '0);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val;
    logic                      left_gt;
    logic signed [VALUE_W-1:0] right_val;
    logic                      valid;

    assign valid = (32'(count_q) > 32'(g));

    if (g == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[g-1];
      assign left_gt  = cell_gt[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_val = cell_val[g];
    end else begin : g_inner
      assign right_val = cell_val[g+1];
    end

    mhpq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .valid_i     (valid),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .val_o       (cell_val[g]),
      .gt_o        (cell_gt[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CNT_W'(64);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- rtl/core/mhpq_checker.sv -----
`timescale 1ns / 1ps

module mhpq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input mhpq_pkg::in_item_t  in_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mhpq_pkg::out_item_t out_o,
  input logic                cfg_we_i,
  input logic [6:0]          cfg_wdata_i
);
  import mhpq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after input transaction");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.is_empty == (out_o.entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.is_empty |-> out_o.minimum == '0)
    else $error("minimum nonzero on empty queue");

  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == ST_FULL || out_o.status == ST_EMPTY)
      |-> out_o.popped_value == '0)
    else $error("refused transaction returned a value");

endmodule

bind min_heap_priority_queue_unit mhpq_checker u_mhpq_checker (.*);

// ----- bench/tb_min_heap_priority_queue_unit.sv -----
`timescale 1ns / 1ps

module tb_min_heap_priority_queue_unit;
  import mhpq_pkg::*;

  localparam int HEAP_DEPTH = 64;
  localparam int N_PHASES = 10;
  localparam int PHASE_ITEMS = 190;

  typedef struct {
    bit        is_cfg;
    logic [6:0] cap;
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_item_t   in_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_item_t  out_o;
  logic       cfg_we_i;
  logic [6:0] cfg_wdata_i;

  logic      typed_valid;
  out_item_t typed_want;

  logic signed [VALUE_W-1:0] heap_q [0:HEAP_DEPTH-1];
  int unsigned heap_count = 0;
  int unsigned heap_cap = 64;

  out_item_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int burst_left = 0;
  bit long_hold_done = 0;

  min_heap_priority_queue_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic out_item_t heap_apply(in_item_t item);
    out_item_t res;
    int unsigned limit, pos, parent, lft, rgt, pick;
    logic signed [VALUE_W-1:0] tmp;
    bit stop;
    res = '0;
    res.status = ST_DONE;
    limit = (heap_cap > HEAP_DEPTH) ? HEAP_DEPTH : heap_cap;
    if (item.operation == OP_PUSH) begin
      if (heap_count >= limit) begin
        res.status = ST_FULL;
      end else begin
        pos = heap_count;
        heap_q[pos] = item.value;
        stop = 0;
        while (pos > 0 && !stop) begin
          parent = (pos - 1) / 2;
          if (heap_q[pos] < heap_q[parent]) begin
            tmp = heap_q[pos];
            heap_q[pos] = heap_q[parent];
            heap_q[parent] = tmp;
            pos = parent;
          end else begin
            stop = 1;
          end
        end
        heap_count++;
      end
    end else if (heap_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.popped_value = heap_q[0];
      heap_count--;
      if (heap_count > 0) begin
        heap_q[0] = heap_q[heap_count];
        pos = 0;
        stop = 0;
        while (!stop) begin
          lft = 2 * pos + 1;
          rgt = lft + 1;
          if (lft >= heap_count) begin
            stop = 1;
          end else begin
            pick = lft;
            if (rgt < heap_count && heap_q[rgt] < heap_q[lft]) pick = rgt;
            if (heap_q[pick] < heap_q[pos]) begin
              tmp = heap_q[pos];
              heap_q[pos] = heap_q[pick];
              heap_q[pick] = tmp;
              pos = pick;
            end else begin
              stop = 1;
            end
          end
        end
      end
    end
    res.minimum = (heap_count > 0) ? heap_q[0] : '0;
    res.entry_count = heap_count[CNT_W-1:0];
    res.is_empty = (heap_count == 0);
    return res;
  endfunction

  task automatic note_error(string msg, out_item_t want, out_item_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t ERROR %s exp st=%0d pop=%0d min=%0d cnt=%0d emp=%0b", $realtime, msg,
               want.status, want.popped_value, want.minimum, want.entry_count, want.is_empty);
      $display("%0t       %s got st=%0d pop=%0d min=%0d cnt=%0d emp=%0b", $realtime, msg,
               got.status, got.popped_value, got.minimum, got.entry_count, got.is_empty);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      if (cfg_we_i) heap_cap = 32'(cfg_wdata_i);
      if (in_valid_i && in_ready_o) begin
        want = heap_apply(in_i);
        pending_results.push_back(typed_valid ? typed_want : want);
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          note_error("unexpected result", '0, out_o);
        end else begin
          want = pending_results.pop_front();
          if (out_o.status !== want.status || out_o.popped_value !== want.popped_value ||
              out_o.minimum !== want.minimum || out_o.entry_count !== want.entry_count ||
              out_o.is_empty !== want.is_empty)
            note_error("mismatch", want, out_o);
        end
      end
    end
  end

  initial begin : receiver
    int rx_cycle;
    rx_cycle = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (!long_hold_done && results_seen >= 500) begin
        long_hold_done = 1;
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        case ((rx_cycle / 97) % 4)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (rx_cycle % 3 == 0);
          default: out_ready_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic send_item(in_item_t item, bit typed, out_item_t want);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_i <= item;
    typed_valid <= typed;
    typed_want <= want;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [6:0] cap);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic dir_row_t row_cfg(logic [6:0] cap);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.cap = cap;
    return r;
  endfunction

  function automatic dir_row_t row_item(op_e op, logic signed [VALUE_W-1:0] val);
    dir_row_t r;
    r = '{default: '0};
    r.item.operation = op;
    r.item.value = val;
    return r;
  endfunction

  function automatic dir_row_t row_checked(op_e op, logic signed [VALUE_W-1:0] val,
                                           status_e st, logic signed [VALUE_W-1:0] popped,
                                           logic signed [VALUE_W-1:0] minv,
                                           logic [CNT_W-1:0] cnt);
    dir_row_t r;
    r = row_item(op, val);
    r.typed = 1;
    r.want.status = st;
    r.want.popped_value = popped;
    r.want.minimum = minv;
    r.want.entry_count = cnt;
    r.want.is_empty = (cnt == 0);
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      4, 5, 6: return $urandom_range(0, 20) - 10;
      7: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      8: return 32'h8000_0000 | $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    dir_row_t dir_rows[$];
    in_item_t item;
    static int phase_cap[N_PHASES] = '{64, 127, 3, 1, 0, 64, 40, 2, 64, 127};
    static int phase_push[N_PHASES] = '{60, 90, 50, 50, 50, 25, 55, 50, 75, 20};

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    typed_valid = 1'b0;
    typed_want = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows.push_back(row_checked(OP_POP, 0, ST_EMPTY, 0, 0, 0));
    dir_rows.push_back(row_checked(OP_PUSH, 32'sh7FFF_FFFF, ST_DONE, 0, 32'sh7FFF_FFFF, 1));
    dir_rows.push_back(row_checked(OP_PUSH, 32'sh8000_0000, ST_DONE, 0, 32'sh8000_0000, 2));
    dir_rows.push_back(row_checked(OP_PUSH, 0, ST_DONE, 0, 32'sh8000_0000, 3));
    dir_rows.push_back(row_item(OP_PUSH, -1));
    dir_rows.push_back(row_item(OP_PUSH, -1));
    repeat (4) dir_rows.push_back(row_item(OP_POP, 0));
    dir_rows.push_back(row_checked(OP_POP, 0, ST_DONE, 32'sh7FFF_FFFF, 0, 0));
    dir_rows.push_back(row_checked(OP_POP, 32'sh7FFF_FFFF, ST_EMPTY, 0, 0, 0));
    dir_rows.push_back(row_cfg(0));
    dir_rows.push_back(row_checked(OP_PUSH, 5, ST_FULL, 0, 0, 0));
    dir_rows.push_back(row_cfg(2));
    dir_rows.push_back(row_item(OP_PUSH, 32'sh5555_5555));
    dir_rows.push_back(row_item(OP_PUSH, 32'shAAAA_AAAA));
    dir_rows.push_back(row_checked(OP_PUSH, 1, ST_FULL, 0, 32'shAAAA_AAAA, 2));
    dir_rows.push_back(row_cfg(1));
    dir_rows.push_back(row_checked(OP_PUSH, 7, ST_FULL, 0, 32'shAAAA_AAAA, 2));
    dir_rows.push_back(row_item(OP_POP, 0));
    dir_rows.push_back(row_item(OP_POP, 0));
    dir_rows.push_back(row_item(OP_PUSH, 3));
    dir_rows.push_back(row_checked(OP_PUSH, 4, ST_FULL, 0, 3, 1));
    dir_rows.push_back(row_cfg(127));
    dir_rows.push_back(row_item(OP_PUSH, 32'sh8000_0000));
    dir_rows.push_back(row_item(OP_PUSH, 32'sh8000_0000));
    dir_rows.push_back(row_item(OP_POP, 0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_results();
        write_capacity(dir_rows[i].cap);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      write_capacity(7'(phase_cap[p]));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        item.operation = ($urandom_range(0, 99) < phase_push[p]) ? OP_PUSH : OP_POP;
        item.value = rand_value();
        send_item(item, 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) note_error("missing result", pending_results[0], '0);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_cell.sv
rtl/core/min_heap_priority_queue_unit.sv
rtl/core/mhpq_checker.sv
bench/tb_min_heap_priority_queue_unit.sv
